[rtl/sorted_integer_set_table_assert.svh]
// ----------------------------------------------------------------------------
// sorted_integer_set_table_assert
// assertion macros of the sorted set rtl
// ----------------------------------------------------------------------------
`ifndef SORTED_INTEGER_SET_TABLE_ASSERT_SVH
`define SORTED_INTEGER_SET_TABLE_ASSERT_SVH

`ifndef ASSERT_OFF
// checked property, masked while reset is asserted
`define SIST_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// checked property, also during reset
`define SIST_ASSERT_NR(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SIST_ASSERT(lbl, clk, rstn, prop, msg)
`define SIST_ASSERT_NR(lbl, clk, prop, msg)
`endif

`endif

[rtl/sist_pkg.sv]
// ----------------------------------------------------------------------------
// sist_pkg
// types and constants of the sorted integer set table
// ----------------------------------------------------------------------------
`default_nettype none

package sist_pkg;

  localparam int CAPACITY_DEF    = 256;
  localparam int KEY_WIDTH_DEF   = 32;
  localparam int COUNT_WIDTH_DEF = $clog2(CAPACITY_DEF + 1);
  localparam int OP_WIDTH        = 3;
  localparam int POS_WIDTH       = 8;
  localparam int STATUS_WIDTH    = 2;

  typedef enum logic [OP_WIDTH-1:0] {
    OP_LOOKUP = 3'd0,
    OP_INSERT = 3'd1,
    OP_REMOVE = 3'd2,
    OP_CLEAR  = 3'd3,
    OP_READ   = 3'd4
  } op_e;

  typedef enum logic [STATUS_WIDTH-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CMP,
    S_RED,
    S_UPD
  } state_e;

  // commands broadcast to every cell
  typedef struct packed {
    logic compare;
    logic ins;
    logic rem;
  } cell_ctl_t;

endpackage

`default_nettype wire

[rtl/sist_req_if.sv]
// ----------------------------------------------------------------------------
// sist_req_if
// request channel: operation, key and position with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface sist_req_if #(
  parameter int KEY_WIDTH = sist_pkg::KEY_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic [sist_pkg::OP_WIDTH-1:0]     operation;
  logic signed [KEY_WIDTH-1:0]       key;
  logic [sist_pkg::POS_WIDTH-1:0]    position;

  modport source (output valid, output operation, output key, output position,
                  input ready);
  modport sink   (input valid, input operation, input key, input position,
                  output ready);
endinterface

`default_nettype wire

[rtl/sist_rsp_if.sv]
// ----------------------------------------------------------------------------
// sist_rsp_if
// result channel: found, count, value and status with valid/ready
// ----------------------------------------------------------------------------
`default_nettype none

interface sist_rsp_if #(
  parameter int KEY_WIDTH   = sist_pkg::KEY_WIDTH_DEF,
  parameter int COUNT_WIDTH = sist_pkg::COUNT_WIDTH_DEF
);
  logic                              valid;
  logic                              ready;
  logic                              found;
  logic [COUNT_WIDTH-1:0]            count;
  logic signed [KEY_WIDTH-1:0]       value;
  logic [sist_pkg::STATUS_WIDTH-1:0] status;

  modport source (output valid, output found, output count, output value,
                  output status, input ready);
  modport sink   (input valid, input found, input count, input value,
                  input status, output ready);
endinterface

`default_nettype wire

[rtl/sist_cell.sv]
// ----------------------------------------------------------------------------
// sist_cell
// one slot of the sorted row: compares against the broadcast key and
// shifts a key up or down from its neighbor
// ----------------------------------------------------------------------------
`default_nettype none

module sist_cell #(
  parameter int IDX       = 0,
  parameter int KEY_WIDTH = sist_pkg::KEY_WIDTH_DEF,
  parameter int CNT_W     = sist_pkg::COUNT_WIDTH_DEF
) (
  input  wire                               clk_i,
  input  wire sist_pkg::cell_ctl_t          ctl_i,
  input  wire logic signed [KEY_WIDTH-1:0]  req_key_i,
  input  wire logic [sist_pkg::POS_WIDTH-1:0] pos_i,
  input  wire logic [CNT_W-1:0]             held_i,
  input  wire logic signed [KEY_WIDTH-1:0]  prev_key_i,
  input  wire logic                         prev_lt_i,
  input  wire logic signed [KEY_WIDTH-1:0]  next_key_i,
  output logic signed [KEY_WIDTH-1:0]       key_o,
  output logic                              lt_o,
  output logic [KEY_WIDTH:0]                hit_o
);

  logic signed [KEY_WIDTH-1:0] key_q, key_d;
  logic                        lt_q;
  logic                        eq_q;
  logic [KEY_WIDTH-1:0]        rd_q;
  logic                        occupied;
  logic                        sel;

  assign occupied = CNT_W'(IDX) < held_i;
  assign sel      = (IDX < (1 << sist_pkg::POS_WIDTH)) &&
                    (pos_i == sist_pkg::POS_WIDTH'(IDX));

  // insert: slots at or above the rank take the new key or the one below
  // remove: slots at or above the rank take the one above
  always_comb begin
    key_d = key_q;
    if (ctl_i.ins && !lt_q) begin
      key_d = prev_lt_i ? req_key_i : prev_key_i;
    end else if (ctl_i.rem && !lt_q) begin
      key_d = next_key_i;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (ctl_i.compare) begin
      lt_q <= occupied && (key_q < req_key_i);
      eq_q <= occupied && (key_q == req_key_i);
      rd_q <= sel ? key_q : '0;
    end
  end

  assign key_o = key_q;
  assign lt_o  = lt_q;
  assign hit_o = {eq_q, rd_q};

endmodule

`default_nettype wire

[rtl/sist_or_tree.sv]
// ----------------------------------------------------------------------------
// sist_or_tree
// registered or-reduction of the per-cell hit words, sixteen to a group
// ----------------------------------------------------------------------------
`default_nettype none

module sist_or_tree #(
  parameter int N = sist_pkg::CAPACITY_DEF,
  parameter int W = sist_pkg::KEY_WIDTH_DEF + 1
) (
  input  wire                     clk_i,
  input  wire logic [N-1:0][W-1:0] data_i,
  output logic [W-1:0]            data_o
);

  localparam int GRP    = 16;
  localparam int GROUPS = (N + GRP - 1) / GRP;

  logic [GROUPS*GRP-1:0][W-1:0] pad;
  logic [GROUPS-1:0][W-1:0]     group_d;
  logic [GROUPS-1:0][W-1:0]     group_q;

  always_comb begin
    pad        = '0;
    pad[N-1:0] = data_i;
  end

  always_comb begin
    for (int g = 0; g < GROUPS; g++) begin
      group_d[g] = '0;
      for (int j = 0; j < GRP; j++) begin
        group_d[g] = group_d[g] | pad[g*GRP + j];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    group_q <= group_d;
  end

  always_comb begin
    data_o = '0;
    for (int g = 0; g < GROUPS; g++) begin
      data_o = data_o | group_q[g];
    end
  end

endmodule

`default_nettype wire

[rtl/sorted_integer_set_table.sv]
// ----------------------------------------------------------------------------
// sorted_integer_set_table
// set of distinct signed keys kept in ascending order in a row of cells
// ----------------------------------------------------------------------------
//  channel  dir  handshake     payload
//  req_i    in   valid/ready   operation, key, position
//  rsp_o    out  valid/ready   found, count, value, status
//
//  every request runs through accept, compare in all cells, or-tree
//  reduction of the cell hits, then the shift update and result load
//  one request is in work at a time; a new one is taken while the previous
//  result still waits in the output register
//  a stalled output holds the update step until the result register frees
//  reset clears the key count and control; cell contents need no reset
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_integer_set_table_assert.svh"

module sorted_integer_set_table #(
  parameter int CAPACITY  = sist_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = sist_pkg::KEY_WIDTH_DEF
) (
  input  wire        clk_i,
  input  wire        rst_ni,
  sist_req_if.sink   req_i,
  sist_rsp_if.source rsp_o
);

  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int WIDE_W = (CNT_W > sist_pkg::POS_WIDTH) ? CNT_W : sist_pkg::POS_WIDTH;

  sist_pkg::state_e state_q, state_d;

  logic [sist_pkg::OP_WIDTH-1:0]  op_q;
  logic signed [KEY_WIDTH-1:0]    key_q;
  logic [sist_pkg::POS_WIDTH-1:0] pos_q;
  logic [CNT_W-1:0]               held_q, held_d;

  logic                           out_valid_q, out_valid_d;
  logic                           found_q, found_d;
  logic [CNT_W-1:0]               count_q, count_d;
  logic signed [KEY_WIDTH-1:0]    value_q, value_d;
  sist_pkg::status_e              status_q, status_d;

  logic                           accept;
  logic                           load;
  logic                           full;
  logic                           in_range;
  logic                           hit_found;
  logic [KEY_WIDTH-1:0]           hit_value;
  sist_pkg::cell_ctl_t            ctl;

  logic [CAPACITY-1:0][KEY_WIDTH-1:0] cell_key;
  logic [CAPACITY-1:0]                cell_lt;
  logic [CAPACITY-1:0][KEY_WIDTH:0]   cell_hit;
  logic [KEY_WIDTH:0]                 tree_out;

  assign req_i.ready = (state_q == sist_pkg::S_IDLE);
  assign accept      = req_i.valid && req_i.ready;
  assign load        = (state_q == sist_pkg::S_UPD) && (!out_valid_q || rsp_o.ready);
  assign full        = (held_q == CNT_W'(CAPACITY));
  assign in_range    = WIDE_W'(pos_q) < WIDE_W'(held_q);
  assign hit_found   = tree_out[KEY_WIDTH];
  assign hit_value   = tree_out[KEY_WIDTH-1:0];

  // ---------------- cell row ----------------

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic signed [KEY_WIDTH-1:0] prev_key;
    logic                        prev_lt;
    logic signed [KEY_WIDTH-1:0] next_key;

    if (i == 0) begin : g_first
      assign prev_key = '0;
      assign prev_lt  = 1'b1;
    end else begin : g_inner_lo
      assign prev_key = cell_key[i-1];
      assign prev_lt  = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign next_key = cell_key[i];
    end else begin : g_inner_hi
      assign next_key = cell_key[i+1];
    end

    sist_cell #(
      .IDX       (i),
      .KEY_WIDTH (KEY_WIDTH),
      .CNT_W     (CNT_W)
    ) u_cell (
      .clk_i      (clk_i),
      .ctl_i      (ctl),
      .req_key_i  (key_q),
      .pos_i      (pos_q),
      .held_i     (held_q),
      .prev_key_i (prev_key),
      .prev_lt_i  (prev_lt),
      .next_key_i (next_key),
      .key_o      (cell_key[i]),
      .lt_o       (cell_lt[i]),
      .hit_o      (cell_hit[i])
    );
  end

  sist_or_tree #(
    .N (CAPACITY),
    .W (KEY_WIDTH + 1)
  ) u_or_tree (
    .clk_i  (clk_i),
    .data_i (cell_hit),
    .data_o (tree_out)
  );

  // ---------------- request capture ----------------

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q  <= req_i.operation;
      key_q <= req_i.key;
      pos_q <= req_i.position;
    end
  end

  // ---------------- sequencer ----------------

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sist_pkg::S_IDLE;
      held_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      held_q      <= held_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      found_q  <= found_d;
      count_q  <= count_d;
      value_q  <= value_d;
      status_q <= status_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    held_d      = held_q;
    out_valid_d = out_valid_q;
    found_d     = 1'b0;
    value_d     = '0;
    status_d    = sist_pkg::ST_OK;
    ctl         = '0;

    if (rsp_o.ready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      sist_pkg::S_IDLE: begin
        if (accept) begin
          state_d = sist_pkg::S_CMP;
        end
      end
      sist_pkg::S_CMP: begin
        ctl.compare = 1'b1;
        state_d     = sist_pkg::S_RED;
      end
      sist_pkg::S_RED: begin
        state_d = sist_pkg::S_UPD;
      end
      sist_pkg::S_UPD: begin
        if (load) begin
          state_d     = sist_pkg::S_IDLE;
          out_valid_d = 1'b1;
          unique case (sist_pkg::op_e'(op_q))
            sist_pkg::OP_LOOKUP: begin
              found_d = hit_found;
            end
            sist_pkg::OP_INSERT: begin
              found_d = hit_found;
              if (!hit_found) begin
                if (full) begin
                  status_d = sist_pkg::ST_FULL;
                end else begin
                  ctl.ins = 1'b1;
                  held_d  = held_q + 1'b1;
                end
              end
            end
            sist_pkg::OP_REMOVE: begin
              found_d = hit_found;
              if (hit_found) begin
                ctl.rem = 1'b1;
                held_d  = held_q - 1'b1;
              end
            end
            sist_pkg::OP_CLEAR: begin
              held_d = '0;
            end
            sist_pkg::OP_READ: begin
              if (in_range) begin
                value_d = hit_value;
              end else begin
                status_d = sist_pkg::ST_RANGE;
              end
            end
            default: begin
              // unused codes leave the set alone
            end
          endcase
        end
      end
      default: begin
        state_d = sist_pkg::S_IDLE;
      end
    endcase
  end

  assign count_d = held_d;

  assign rsp_o.valid  = out_valid_q;
  assign rsp_o.found  = found_q;
  assign rsp_o.count  = count_q;
  assign rsp_o.value  = value_q;
  assign rsp_o.status = status_q;

  // ---------------- assertions ----------------

  `SIST_ASSERT_NR(a_held_bound, clk_i, (held_q <= CNT_W'(CAPACITY)), "key count above capacity")

  `SIST_ASSERT(a_count_tracks, clk_i, rst_ni, (out_valid_q |-> (count_q == held_q)), "result count differs from key count")

  `SIST_ASSERT(a_full_result, clk_i, rst_ni, ((out_valid_q && status_q == sist_pkg::ST_FULL) |-> (!found_q && held_q == CNT_W'(CAPACITY))), "full status without a full set")

  `SIST_ASSERT(a_upd_stall, clk_i, rst_ni, ((state_q == sist_pkg::S_UPD && out_valid_q && !rsp_o.ready) |=> (state_q == sist_pkg::S_UPD && $stable(held_q))), "update went ahead of a stalled result")

endmodule

`default_nettype wire
